FILE: sv/xtsc_pkg.sv
// shared types and constants for the xor trie subarray counter
package xtsc_pkg;

    // fixed field widths
    localparam int VAL_W   = 21;
    localparam int COUNT_W = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // walk control flags handed from cell to cell
    typedef struct packed {
        logic qen;     // query walk enabled for this pass
        logic qalive;  // query walk still on a node
        logic qnew;    // query node is freshly cleared
        logic inew;    // insert node is freshly cleared
    } ctl_t;

endpackage

FILE: sv/xtsc_cell.sv
// one trie level: node memory, query step and insert step
module xtsc_cell #(
    parameter int VALUE_BITS = 21,
    parameter int LEVEL      = 0,
    parameter int ID_W       = 17,
    parameter int CNT_W      = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  xtsc_pkg::ctl_t        in_ctl,
    input  logic [VALUE_BITS-1:0] in_p,
    input  logic [VALUE_BITS-1:0] in_thr,
    input  logic [ID_W-1:0]       in_qcur,
    input  logic [ID_W-1:0]       in_icur,
    input  logic [CNT_W-1:0]      in_sum,
    input  logic [ID_W:0]         in_nfree,
    output logic                  out_valid,
    output xtsc_pkg::ctl_t        out_ctl,
    output logic [VALUE_BITS-1:0] out_p,
    output logic [VALUE_BITS-1:0] out_thr,
    output logic [ID_W-1:0]       out_qcur,
    output logic [ID_W-1:0]       out_icur,
    output logic [CNT_W-1:0]      out_sum,
    output logic [ID_W:0]         out_nfree
);
    import xtsc_pkg::*;

    localparam int DEPTH = 1 << ID_W;
    localparam int ENT_W = 2 * CNT_W + 2 * ID_W;

    // entry layout from low bits: cnt0, cnt1, child0, child1
    logic [ENT_W-1:0] mem [DEPTH];

    logic                  act_reg;
    ctl_t                  ctl_reg;
    logic [VALUE_BITS-1:0] p_reg;
    logic [VALUE_BITS-1:0] thr_reg;
    logic [ID_W-1:0]       icur_reg;
    logic [CNT_W-1:0]      sum_reg;
    logic [ID_W:0]         nfree_reg;
    logic [ENT_W-1:0]      rdq_reg;
    logic [ENT_W-1:0]      rdi_reg;

    logic [ENT_W-1:0] qd, id, wr_next;
    logic [CNT_W-1:0] qcnt [2];
    logic [ID_W-1:0]  qch [2];
    logic [CNT_W-1:0] icnt [2];
    logic [ID_W-1:0]  ich [2];
    logic             x, y;
    logic [ID_W-1:0]  qnxt, inxt;
    ctl_t             ctl_next;
    logic [CNT_W-1:0] sum_next;
    logic [ID_W:0]    nfree_next;

    // node reads, registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
        end else begin
            act_reg <= in_valid;
        end
        if (in_valid) begin
            rdq_reg   <= mem[in_qcur];
            rdi_reg   <= mem[in_icur];
            ctl_reg   <= in_ctl;
            p_reg     <= in_p;
            thr_reg   <= in_thr;
            icur_reg  <= in_icur;
            sum_reg   <= in_sum;
            nfree_reg <= in_nfree;
        end
    end

    // query and insert step at this level
    always_comb begin
        qd = ctl_reg.qnew ? '0 : rdq_reg;
        id = ctl_reg.inew ? '0 : rdi_reg;
        qcnt[0] = qd[CNT_W-1:0];
        qcnt[1] = qd[2*CNT_W-1:CNT_W];
        qch[0]  = qd[2*CNT_W+ID_W-1:2*CNT_W];
        qch[1]  = qd[ENT_W-1:2*CNT_W+ID_W];
        icnt[0] = id[CNT_W-1:0];
        icnt[1] = id[2*CNT_W-1:CNT_W];
        ich[0]  = id[2*CNT_W+ID_W-1:2*CNT_W];
        ich[1]  = id[ENT_W-1:2*CNT_W+ID_W];
        x = p_reg[LEVEL];
        y = thr_reg[LEVEL];

        ctl_next   = ctl_reg;
        sum_next   = sum_reg;
        qnxt       = '0;
        ctl_next.qnew = 1'b0;
        if (ctl_reg.qen && ctl_reg.qalive) begin
            if (y) begin
                sum_next = sum_reg + qcnt[x];
                qnxt     = qch[~x];
            end else begin
                qnxt = qch[x];
            end
            ctl_next.qalive = (qnxt != '0);
        end else begin
            ctl_next.qalive = 1'b0;
        end

        // insert: bump count, allocate child when missing
        icnt[x]    = icnt[x] + 1'b1;
        nfree_next = nfree_reg;
        if (ich[x] == '0) begin
            ich[x]        = nfree_reg[ID_W-1:0];
            nfree_next    = nfree_reg + 1'b1;
            ctl_next.inew = 1'b1;
        end else begin
            ctl_next.inew = 1'b0;
        end
        inxt    = ich[x];
        wr_next = {ich[1], ich[0], icnt[1], icnt[0]};
    end

    // node write and handoff to the next level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else begin
            out_valid <= act_reg;
        end
        if (act_reg) begin
            mem[icur_reg] <= wr_next;
            out_ctl   <= ctl_next;
            out_p     <= p_reg;
            out_thr   <= thr_reg;
            out_qcur  <= qnxt;
            out_icur  <= inxt;
            out_sum   <= sum_next;
            out_nfree <= nfree_next;
        end
    end

endmodule

FILE: sv/xor_trie_subarray_counter.sv
// top level: sequence control, threshold register and the chain of trie level cells
//
// Counts subarrays of a stream whose xor is below a threshold.
// Input s_*: tdata carries one 21-bit element, tuser marks the first item of a
// sequence (clears the trie and prefix, then inserts prefix zero).
// Output m_*: tdata carries the running count, tuser flags an ignored item.
// Configuration cfg_*: one write sets the threshold; ready is always high.
// Each item walks the trie through one cell per bit level, each level a
// registered node read, then a node write. A first item also makes the
// walk that inserts prefix zero before its own walk; an ignored item
// makes no walk and goes straight to its result.
// One item is worked on at a time; s_tready is high only while idle.
// The result sits in an output register; a stalled receiver holds the block
// in its final state until the result is taken.
// Reset clears control state and marks the root as empty; node memories need
// no clearing pass since every new node is marked fresh when allocated.
module xor_trie_subarray_counter #(
    parameter int VALUE_BITS = 21,
    parameter int MAX_ITEMS  = 4096,
    parameter int NODE_COUNT = 131072
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] value, rest zero
    input  logic        s_tuser,   // [0] first_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] running_count
    output logic        m_tuser,   // [0] overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data   // threshold
);
    import xtsc_pkg::*;

    localparam int ID_W  = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(MAX_ITEMS + 2);
    localparam int IT_W  = $clog2(MAX_ITEMS + 1);
    localparam int VB    = VALUE_BITS;
    localparam logic [ID_W+1:0] NC_X  = (ID_W + 2)'(NODE_COUNT);
    localparam logic [ID_W+1:0] VB_X  = (ID_W + 2)'(VALUE_BITS);
    localparam logic [IT_W-1:0] MAX_X = IT_W'(MAX_ITEMS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHK  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]         state_reg;
    logic               main_reg;
    logic               root_fresh_reg;
    logic [VAL_W-1:0]   thr_raw_reg;
    logic [VB-1:0]      v_reg;
    logic [VB-1:0]      prefix_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [IT_W-1:0]    items_reg;
    logic [ID_W:0]      nfree_reg;
    logic               ovf_reg;
    logic               m_tvalid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_ovf_reg;

    logic               launch_reg;
    ctl_t               lctl_reg;
    logic [VB-1:0]      lp_reg;

    logic [VB+VAL_W-1:0] v_wide, thr_wide;
    logic [VB-1:0]       v_in, thr;
    logic                guard_bad;
    logic [COUNT_W:0]    total_sum;

    // chain links
    logic                  c_valid [VB+1];
    ctl_t                  c_ctl   [VB+1];
    logic [VB-1:0]         c_p     [VB+1];
    logic [VB-1:0]         c_thr   [VB+1];
    logic [ID_W-1:0]       c_qcur  [VB+1];
    logic [ID_W-1:0]       c_icur  [VB+1];
    logic [CNT_W-1:0]      c_sum   [VB+1];
    logic [ID_W:0]         c_nfree [VB+1];

    // field masking to the value width
    assign v_wide   = {{VB{1'b0}}, s_tdata[VAL_W-1:0]};
    assign thr_wide = {{VB{1'b0}}, thr_raw_reg};
    assign v_in     = v_wide[VB-1:0];
    assign thr      = thr_wide[VB-1:0];

    assign guard_bad = (items_reg >= MAX_X) || (({1'b0, nfree_reg} + VB_X) > NC_X);
    assign total_sum = {1'b0, total_reg} + (COUNT_W + 1)'(c_sum[VB]);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_count_reg;
    assign m_tuser   = m_ovf_reg;

    // chain head
    assign c_valid[0] = launch_reg;
    assign c_ctl[0]   = lctl_reg;
    assign c_p[0]     = lp_reg;
    assign c_thr[0]   = thr;
    assign c_qcur[0]  = '0;
    assign c_icur[0]  = '0;
    assign c_sum[0]   = '0;
    assign c_nfree[0] = nfree_reg;

    // one cell per level, top bit first
    for (genvar k = 0; k < VB; k++) begin : g_cell
        xtsc_cell #(
            .VALUE_BITS(VB),
            .LEVEL     (VB - 1 - k),
            .ID_W      (ID_W),
            .CNT_W     (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (c_valid[k]),
            .in_ctl   (c_ctl[k]),
            .in_p     (c_p[k]),
            .in_thr   (c_thr[k]),
            .in_qcur  (c_qcur[k]),
            .in_icur  (c_icur[k]),
            .in_sum   (c_sum[k]),
            .in_nfree (c_nfree[k]),
            .out_valid(c_valid[k+1]),
            .out_ctl  (c_ctl[k+1]),
            .out_p    (c_p[k+1]),
            .out_thr  (c_thr[k+1]),
            .out_qcur (c_qcur[k+1]),
            .out_icur (c_icur[k+1]),
            .out_sum  (c_sum[k+1]),
            .out_nfree(c_nfree[k+1])
        );
    end

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_raw_reg <= '0;
        end else if (cfg_valid) begin
            thr_raw_reg <= cfg_data;
        end
    end

    // sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            main_reg       <= 1'b0;
            root_fresh_reg <= 1'b1;
            prefix_reg     <= '0;
            total_reg      <= '0;
            items_reg      <= '0;
            nfree_reg      <= (ID_W + 1)'(1);
            ovf_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            launch_reg     <= 1'b0;
        end else begin
            launch_reg <= 1'b0;
            // result taken; the final state reloads the register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        v_reg <= v_in;
                        if (s_tuser) begin
                            // new sequence: clear, then insert prefix zero
                            prefix_reg     <= '0;
                            total_reg      <= '0;
                            items_reg      <= '0;
                            nfree_reg      <= (ID_W + 1)'(1);
                            root_fresh_reg <= 1'b0;
                            lctl_reg       <= '{qen: 1'b0, qalive: 1'b0,
                                                qnew: 1'b1, inew: 1'b1};
                            lp_reg         <= '0;
                            launch_reg     <= 1'b1;
                            main_reg       <= 1'b0;
                            state_reg      <= ST_RUN;
                        end else begin
                            state_reg <= ST_CHK;
                        end
                    end
                end
                ST_CHK: begin
                    if (guard_bad) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_FIN;
                    end else begin
                        ovf_reg        <= 1'b0;
                        prefix_reg     <= prefix_reg ^ v_reg;
                        lp_reg         <= prefix_reg ^ v_reg;
                        lctl_reg       <= '{qen: 1'b1, qalive: 1'b1,
                                            qnew: root_fresh_reg, inew: root_fresh_reg};
                        root_fresh_reg <= 1'b0;
                        launch_reg     <= 1'b1;
                        main_reg       <= 1'b1;
                        state_reg      <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (c_valid[VB]) begin
                        nfree_reg <= c_nfree[VB];
                        if (main_reg) begin
                            total_reg <= total_sum[COUNT_W] ? COUNT_MAX
                                                            : total_sum[COUNT_W-1:0];
                            items_reg <= items_reg + 1'b1;
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= ST_CHK;
                        end
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_count_reg  <= total_reg;
                        m_ovf_reg    <= ovf_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
